@@ src/gmcg_pkg.sv @@
// Shared types and constants of the cloth grid connectivity generator.
package gmcg_pkg;

    // Largest side length in quads; register values above it are clamped.
    localparam int unsigned MAX_SIDE = 256;

    // Field widths.
    localparam int unsigned SIDE_W   = 9;
    localparam int unsigned VERTEX_W = 17;
    localparam int unsigned INDEX_W  = 19;
    localparam int unsigned PHASE_W  = 3;

    // Phase codes within a list.
    localparam logic [PHASE_W-1:0] PH_FIRST  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SECOND = 3'd1;
    localparam logic [PHASE_W-1:0] PH_THIRD  = 3'd2;

    // Register indexes of the configuration port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Connectivity list selector; the last code selects an empty list.
    typedef enum logic [1:0] {
        LIST_TRI    = 2'd0,
        LIST_SPRING = 2'd1,
        LIST_BEND   = 2'd2,
        LIST_NONE   = 2'd3
    } t_list;

    // Rest length code of a spring.
    typedef enum logic [1:0] {
        LEN_EDGE   = 2'd0,
        LEN_DIAG   = 2'd1,
        LEN_DOUBLE = 2'd2
    } t_len;

    // Walk position inside the current list.
    typedef struct packed {
        t_list               list;
        logic [PHASE_W-1:0]  phase;
        logic [SIDE_W-1:0]   col;
        logic [SIDE_W-1:0]   row;
        logic [1:0]          slot;
    } t_walk;

    // One element of a connectivity list.
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [VERTEX_W-1:0] vertex_c;
        t_len                length_code;
    } t_elem;

endpackage

@@ src/gmcg_elem.sv @@
// Vertex index arithmetic for the element at the current walk position.
module gmcg_elem (
    input  gmcg_pkg::t_walk                  i_walk,
    input  logic [gmcg_pkg::SIDE_W-1:0]      i_width,
    input  logic [gmcg_pkg::SIDE_W-1:0]      i_height,
    output gmcg_pkg::t_elem                  o_elem
);
    import gmcg_pkg::*;

    logic [SIDE_W:0]    stride;
    logic [SIDE_W-1:0]  row_sel;
    logic [INDEX_W-1:0] base;
    logic [INDEX_W-1:0] stride_x;
    logic [INDEX_W-1:0] a;
    logic [INDEX_W-1:0] b;
    logic [INDEX_W-1:0] c;
    t_len               code;

    // Row stride of the vertex grid and the start vertex of the current cell.
    // The top-edge springs sit on the last vertex row.
    assign stride   = {1'b0, i_width} + 1'b1;
    assign stride_x = INDEX_W'(stride);
    assign row_sel  = (i_walk.list == LIST_SPRING && i_walk.phase == PH_THIRD)
                      ? i_height : i_walk.row;
    assign base     = INDEX_W'(stride) * INDEX_W'(row_sel) + INDEX_W'(i_walk.col);

    // Element vertices by list, phase and slot.
    always_comb begin
        a    = base;
        b    = '0;
        c    = '0;
        code = LEN_EDGE;
        unique case (i_walk.list)
            LIST_TRI: begin
                if (i_walk.slot == 2'd0) begin
                    b = base + 1'b1;
                    c = base + stride_x;
                end else begin
                    a = base + stride_x;
                    b = base + 1'b1;
                    c = base + stride_x + 1'b1;
                end
            end
            LIST_SPRING: begin
                if (i_walk.phase == PH_FIRST) begin
                    unique case (i_walk.slot)
                        2'd0: b = base + 1'b1;
                        2'd1: begin
                            b    = base + stride_x + 1'b1;
                            code = LEN_DIAG;
                        end
                        2'd2: b = base + stride_x;
                        default: begin
                            a    = base + stride_x;
                            b    = base + 1'b1;
                            code = LEN_DIAG;
                        end
                    endcase
                end else if (i_walk.phase == PH_SECOND) begin
                    // Right-edge springs: column is zero, offset by the width.
                    a = base + INDEX_W'(i_width);
                    b = base + INDEX_W'(i_width) + stride_x;
                end else begin
                    b = base + 1'b1;
                end
            end
            LIST_BEND: begin
                code = LEN_DOUBLE;
                if (i_walk.phase == PH_FIRST) begin
                    b = base + 2'd2;
                end else begin
                    b = base + {stride_x[INDEX_W-2:0], 1'b0};
                end
            end
            default: begin
                a = '0;
            end
        endcase
    end

    assign o_elem.vertex_a    = a[VERTEX_W-1:0];
    assign o_elem.vertex_b    = b[VERTEX_W-1:0];
    assign o_elem.vertex_c    = c[VERTEX_W-1:0];
    assign o_elem.length_code = code;

endmodule

@@ src/grid_mesh_connectivity_generator.sv @@
// Top level of the cloth grid connectivity generator with its register port.
// An input transfer's result is registered in the output register.
// Throughput: one item per cycle while the receiver takes results; the path from the
// walk registers through one stride multiply and add into the output register sets the cycle.
// Reset (synchronous, active low) sets width and height to 4, selects triangles
// and marks the list as finished, so a restart is needed before elements appear.
module grid_mesh_connectivity_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [1:0] list_select, [7:2] zero
    input  logic [0:0]  i_s_tuser,   // [0] action
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [16:0] vertex_a, [33:17] vertex_b, [50:34] vertex_c,
    // [52:51] length_code, [71:53] element_index
    output logic [71:0] o_m_tdata,
    output logic        o_m_tlast,   // last_element
    output logic [0:0]  o_m_tuser,   // [0] element_valid
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gmcg_pkg::*;

    typedef struct packed {
        logic [2:0]        slots;
        logic [SIDE_W:0]   cols;
        logic [SIDE_W:0]   rows;
        logic              col_major;
    } t_shape;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               done;
    } t_settle;

    // Number of phases in a list.
    function automatic logic [PHASE_W-1:0] phase_total(input t_list l);
        logic [PHASE_W-1:0] n;
        unique case (l)
            LIST_TRI:    n = 3'd1;
            LIST_SPRING: n = 3'd3;
            LIST_BEND:   n = 3'd2;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

    // Slots per cell, cell columns and rows, and walk order of one phase.
    function automatic t_shape phase_shape(input t_list l, input logic [PHASE_W-1:0] ph,
                                           input logic [SIDE_W-1:0] w,
                                           input logic [SIDE_W-1:0] h);
        t_shape s;
        s.slots     = 3'd1;
        s.cols      = '0;
        s.rows      = '0;
        s.col_major = 1'b0;
        if (l == LIST_TRI && ph == PH_FIRST) begin
            s.slots = 3'd2;
            s.cols  = {1'b0, w};
            s.rows  = {1'b0, h};
        end else if (l == LIST_SPRING && ph == PH_FIRST) begin
            s.slots = 3'd4;
            s.cols  = {1'b0, w};
            s.rows  = {1'b0, h};
        end else if (l == LIST_SPRING && ph == PH_SECOND) begin
            s.cols = 10'd1;
            s.rows = {1'b0, h};
        end else if (l == LIST_SPRING && ph == PH_THIRD) begin
            s.cols = {1'b0, w};
            s.rows = 10'd1;
        end else if (l == LIST_BEND && ph == PH_FIRST) begin
            s.cols = (w >= 9'd2) ? {1'b0, w} - 1'b1 : '0;
            s.rows = {1'b0, h} + 1'b1;
        end else if (l == LIST_BEND && ph == PH_SECOND) begin
            s.cols      = {1'b0, w} + 1'b1;
            s.rows      = (h >= 9'd2) ? {1'b0, h} - 1'b1 : '0;
            s.col_major = 1'b1;
        end
        return s;
    endfunction

    // First non-empty phase at or after the given one.
    function automatic t_settle settle(input t_list l, input logic [PHASE_W-1:0] ph,
                                       input logic [SIDE_W-1:0] w,
                                       input logic [SIDE_W-1:0] h);
        t_settle res;
        t_shape  sh;
        logic    found;
        res.phase = ph;
        res.done  = 1'b1;
        found     = 1'b0;
        for (int p = 0; p < 3; p++) begin
            sh = phase_shape(l, PHASE_W'(p), w, h);
            if (!found && PHASE_W'(p) >= ph && PHASE_W'(p) < phase_total(l)
                && sh.cols != '0 && sh.rows != '0) begin
                found     = 1'b1;
                res.phase = PHASE_W'(p);
                res.done  = 1'b0;
            end
        end
        return res;
    endfunction

    logic [SIDE_W-1:0]  r_grid_width;
    logic [SIDE_W-1:0]  r_grid_height;
    t_walk              r_walk;
    t_walk              n_walk;
    logic [INDEX_W-1:0] r_count;
    logic [INDEX_W-1:0] n_count;
    logic               r_done;
    logic               n_done;
    logic               r_out_valid;
    logic [71:0]        r_out_data;
    logic [71:0]        n_out_data;
    logic               r_out_last;
    logic               n_out_last;
    logic               r_out_elem;
    logic               n_out_elem;

    logic [SIDE_W-1:0]  width;
    logic [SIDE_W-1:0]  height;
    logic               s_xfer;
    logic               m_xfer;
    logic               cfg_wr;
    logic               restart;
    t_elem              elem;
    t_shape             shape;
    t_settle            st;
    logic [2:0]         slot_inc;
    logic [SIDE_W:0]    col_inc;
    logic [SIDE_W:0]    row_inc;
    t_walk              step;
    logic               phase_end;

    // Register port: always ready, width and height at word addresses 0 and 1.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(r_grid_height) : 32'(r_grid_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 9'd4;
            r_grid_height <= 9'd4;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_grid_width <= pwdata[SIDE_W-1:0];
            end else begin
                r_grid_height <= pwdata[SIDE_W-1:0];
            end
        end
    end

    // Sides clamped to the largest supported grid.
    assign width  = (11'(r_grid_width) > 11'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_grid_width;
    assign height = (11'(r_grid_height) > 11'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_grid_height;

    // Handshakes: the output register frees itself when its result is taken.
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign m_xfer     = o_m_tvalid && i_m_tready;
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign restart    = i_s_tuser[0];

    gmcg_elem u_elem (
        .i_walk   (r_walk),
        .i_width  (width),
        .i_height (height),
        .o_elem   (elem)
    );

    // Step the counters of the current phase by one slot.
    always_comb begin
        shape     = phase_shape(r_walk.list, r_walk.phase, width, height);
        slot_inc  = {1'b0, r_walk.slot} + 1'b1;
        col_inc   = {1'b0, r_walk.col} + 1'b1;
        row_inc   = {1'b0, r_walk.row} + 1'b1;
        step      = r_walk;
        phase_end = 1'b0;
        if (slot_inc >= shape.slots) begin
            step.slot = 2'd0;
            if (!shape.col_major) begin
                step.col = col_inc[SIDE_W-1:0];
                if (col_inc >= shape.cols) begin
                    step.col  = '0;
                    step.row  = row_inc[SIDE_W-1:0];
                    phase_end = (row_inc >= shape.rows);
                end
            end else begin
                step.row = row_inc[SIDE_W-1:0];
                if (row_inc >= shape.rows) begin
                    step.row  = '0;
                    step.col  = col_inc[SIDE_W-1:0];
                    phase_end = (col_inc >= shape.cols);
                end
            end
        end else begin
            step.slot = slot_inc[1:0];
        end
        if (phase_end) begin
            step.phase = r_walk.phase + 1'b1;
            step.col   = '0;
            step.row   = '0;
            step.slot  = 2'd0;
        end
    end

    // Next walk state and the result of the accepted item.
    always_comb begin
        n_walk     = r_walk;
        n_count    = r_count;
        n_done     = r_done;
        n_out_data = '0;
        n_out_last = 1'b0;
        n_out_elem = 1'b0;
        st         = settle(step.list, step.phase, width, height);
        if (s_xfer) begin
            if (restart) begin
                n_walk.list  = t_list'(i_s_tdata[1:0]);
                n_walk.phase = PH_FIRST;
                n_walk.col   = '0;
                n_walk.row   = '0;
                n_walk.slot  = 2'd0;
                n_count      = '0;
                st           = settle(t_list'(i_s_tdata[1:0]), PH_FIRST, width, height);
                n_walk.phase = st.phase;
                n_done       = st.done;
            end else if (!r_done) begin
                n_walk       = step;
                n_walk.phase = st.phase;
                n_done       = st.done;
                n_count      = r_count + 1'b1;
                n_out_data   = {r_count, elem.length_code, elem.vertex_c,
                                elem.vertex_b, elem.vertex_a};
                n_out_last   = st.done;
                n_out_elem   = 1'b1;
            end
        end
        // A register write ends the list in progress.
        if (cfg_wr) begin
            n_done = 1'b1;
        end
    end

    // Walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk  <= '{list: LIST_TRI, phase: PH_FIRST, col: '0, row: '0, slot: 2'd0};
            r_count <= '0;
            r_done  <= 1'b1;
        end else begin
            r_walk  <= n_walk;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
            r_out_elem <= n_out_elem;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tlast    = r_out_last;
    assign o_m_tuser[0] = r_out_elem;

    // A last element is always a real element.
    a_last_is_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[0])
        else $error("last element flagged on an empty result");

    // An empty result carries all-zero data.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("empty result carries data");

    // Emitting the last element finishes the list.
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && n_out_last |=> r_done)
        else $error("list not finished after its last element");

    // A register write finishes the list in progress.
    a_cfg_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> r_done)
        else $error("register write did not end the list");

    // While a list runs, the walk stays inside its phase's shape.
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done |-> ({1'b0, r_walk.slot} < shape.slots) && ({1'b0, r_walk.col} < shape.cols)
                    && ({1'b0, r_walk.row} < shape.rows))
        else $error("walk position outside the current phase");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the cloth grid connectivity generator.
`timescale 1ns / 1ps

module tb_top;
    import gmcg_pkg::*;

    // Request codes carried in tuser.
    localparam logic ACT_NEXT    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASE_ITEMS   = 120;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned HOLD_AFTER    = 300;

    // One element as it leaves the block.
    typedef struct packed {
        t_elem              elem;
        logic [INDEX_W-1:0] idx;
        logic               last;
        logic               valid;
    } t_result;

    // A row of the directed script is either a request or a register write.
    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               act;
        logic [1:0]         sel;
        logic               reg_idx;
        logic [SIDE_W-1:0]  value;
        logic               typed;
        t_result            want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // [1:0] list_select, [7:2] zero
    logic [0:0]  i_s_tuser = '0;   // [0] action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [16:0] vertex_a, [33:17] vertex_b, [50:34] vertex_c,
    // [52:51] length_code, [71:53] element_index
    logic [71:0] o_m_tdata;
    logic        o_m_tlast;        // last_element
    logic [0:0]  o_m_tuser;        // [0] element_valid
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the walk state and the registers.
    logic [SIDE_W-1:0]  cfg_w = 9'd4;
    logic [SIDE_W-1:0]  cfg_h = 9'd4;
    t_list              walk_list = LIST_TRI;
    logic [PHASE_W-1:0] walk_phase = PH_FIRST;
    logic [SIDE_W-1:0]  walk_col = '0;
    logic [SIDE_W-1:0]  walk_row = '0;
    logic [1:0]         walk_slot = '0;
    logic [INDEX_W-1:0] walk_count = '0;
    bit                 walk_done = 1'b1;

    t_result     pending_elems[$];
    t_row        script[$];
    int unsigned faults = 0;
    int unsigned results_seen = 0;
    int unsigned requests_sent = 0;
    int unsigned cycles = 0;
    int unsigned rx_wait = 0;
    bit          rx_hold = 1'b0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    grid_mesh_connectivity_generator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    // Register values above the largest side are used as the largest side.
    function automatic int unsigned clamp_side(logic [SIDE_W-1:0] v);
        return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    function automatic int unsigned phases_of(t_list l);
        case (l)
            LIST_TRI:    return 1;
            LIST_SPRING: return 3;
            LIST_BEND:   return 2;
            default:     return 0;
        endcase
    endfunction

    // Slots per cell, columns, rows and walk order of one phase of a list.
    function automatic void phase_dims(input t_list l, input logic [PHASE_W-1:0] ph,
                                       output int unsigned slots,
                                       output int unsigned cols,
                                       output int unsigned rows,
                                       output bit by_column);
        int unsigned w;
        int unsigned h;
        w = clamp_side(cfg_w);
        h = clamp_side(cfg_h);
        slots = 1;
        cols = 0;
        rows = 0;
        by_column = 1'b0;
        if (l == LIST_TRI && ph == PH_FIRST) begin
            slots = 2; cols = w; rows = h;
        end else if (l == LIST_SPRING && ph == PH_FIRST) begin
            slots = 4; cols = w; rows = h;
        end else if (l == LIST_SPRING && ph == PH_SECOND) begin
            cols = 1; rows = h;
        end else if (l == LIST_SPRING && ph == PH_THIRD) begin
            cols = w; rows = 1;
        end else if (l == LIST_BEND && ph == PH_FIRST) begin
            cols = (w >= 2) ? w - 1 : 0;
            rows = h + 1;
        end else if (l == LIST_BEND && ph == PH_SECOND) begin
            cols = w + 1;
            rows = (h >= 2) ? h - 1 : 0;
            by_column = 1'b1;
        end
    endfunction

    // Moves past phases that hold no elements; marks the list done at its end.
    function automatic void skip_empty();
        int unsigned s;
        int unsigned c;
        int unsigned r;
        bit cm;
        while (walk_phase < phases_of(walk_list)) begin
            phase_dims(walk_list, walk_phase, s, c, r, cm);
            if (c != 0 && r != 0) return;
            walk_phase = walk_phase + 1'b1;
            walk_col = '0;
            walk_row = '0;
            walk_slot = '0;
        end
        walk_done = 1'b1;
    endfunction

    // Steps the walk by one element.
    function automatic void step_walk();
        int unsigned s;
        int unsigned c;
        int unsigned r;
        int unsigned nslot;
        bit cm;
        bit wrap;
        phase_dims(walk_list, walk_phase, s, c, r, cm);
        wrap = 1'b0;
        nslot = walk_slot + 1;
        if (nslot >= s) begin
            walk_slot = '0;
            if (!cm) begin
                walk_col = walk_col + 1'b1;
                if (walk_col >= c) begin
                    walk_col = '0;
                    walk_row = walk_row + 1'b1;
                    if (walk_row >= r) wrap = 1'b1;
                end
            end else begin
                walk_row = walk_row + 1'b1;
                if (walk_row >= r) begin
                    walk_row = '0;
                    walk_col = walk_col + 1'b1;
                    if (walk_col >= c) wrap = 1'b1;
                end
            end
        end else begin
            walk_slot = nslot[1:0];
        end
        if (wrap) begin
            walk_phase = walk_phase + 1'b1;
            walk_col = '0;
            walk_row = '0;
            walk_slot = '0;
        end
        skip_empty();
    endfunction

    // Computes the element that a request produces and advances the walk.
    function automatic t_result predict_element(logic act, logic [1:0] sel);
        t_result     res;
        int unsigned w;
        int unsigned h;
        int unsigned stride;
        int unsigned base;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        t_len        len;
        res = '0;
        w = clamp_side(cfg_w);
        h = clamp_side(cfg_h);
        stride = w + 1;
        base = walk_col + stride * walk_row;
        a = 0;
        b = 0;
        c = 0;
        len = LEN_EDGE;
        if (act == ACT_RESTART) begin
            walk_list = t_list'(sel);
            walk_phase = PH_FIRST;
            walk_col = '0;
            walk_row = '0;
            walk_slot = '0;
            walk_count = '0;
            walk_done = 1'b0;
            skip_empty();
            return res;
        end
        if (walk_done) return res;
        case (walk_list)
            LIST_TRI: begin
                if (walk_slot == 2'd0) begin
                    a = base; b = base + 1; c = base + stride;
                end else begin
                    a = base + stride; b = base + 1; c = base + stride + 1;
                end
            end
            LIST_SPRING: begin
                if (walk_phase == PH_FIRST) begin
                    // Bottom, rising diagonal, left, falling diagonal.
                    case (walk_slot)
                        2'd0: begin a = base; b = base + 1; len = LEN_EDGE; end
                        2'd1: begin a = base; b = base + stride + 1; len = LEN_DIAG; end
                        2'd2: begin a = base; b = base + stride; len = LEN_EDGE; end
                        default: begin a = base + stride; b = base + 1; len = LEN_DIAG; end
                    endcase
                end else if (walk_phase == PH_SECOND) begin
                    a = stride * walk_row + w;
                    b = a + stride;
                end else begin
                    a = stride * h + walk_col;
                    b = a + 1;
                end
            end
            default: begin
                len = LEN_DOUBLE;
                a = base;
                b = (walk_phase == PH_FIRST) ? base + 2 : base + 2 * stride;
            end
        endcase
        res.elem.vertex_a = a[VERTEX_W-1:0];
        res.elem.vertex_b = b[VERTEX_W-1:0];
        res.elem.vertex_c = c[VERTEX_W-1:0];
        res.elem.length_code = len;
        res.idx = walk_count;
        res.valid = 1'b1;
        walk_count = walk_count + 1'b1;
        step_walk();
        res.last = walk_done;
        return res;
    endfunction

    function automatic t_result elem_at(int unsigned a, int unsigned b, int unsigned c,
                                        t_len len, int unsigned idx, bit last);
        t_result r;
        r.elem.vertex_a = a[VERTEX_W-1:0];
        r.elem.vertex_b = b[VERTEX_W-1:0];
        r.elem.vertex_c = c[VERTEX_W-1:0];
        r.elem.length_code = len;
        r.idx = idx[INDEX_W-1:0];
        r.last = last;
        r.valid = 1'b1;
        return r;
    endfunction

    function automatic t_row req_row(logic act, logic [1:0] sel);
        t_row r;
        r = '0;
        r.kind = ROW_REQ;
        r.act = act;
        r.sel = sel;
        return r;
    endfunction

    function automatic t_row req_known(logic act, logic [1:0] sel, t_result want);
        t_row r;
        r = req_row(act, sel);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic t_row cfg_row(logic idx, logic [SIDE_W-1:0] value);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.value = value;
        return r;
    endfunction

    task automatic log_fault(string msg);
        faults++;
        $display("tb_top: mismatch: %s", msg);
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            log_fault($sformatf("element %0d %s got 0x%0h want 0x%0h",
                                results_seen, name, got, want));
    endtask

    // Offers one request after a random gap and predicts its element on transfer.
    task automatic push_request(logic act, logic [1:0] sel, logic typed, t_result want);
        int unsigned gap;
        t_result     got;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {6'd0, sel};
        i_s_tuser <= act;
        do @(posedge i_clk); while (!o_s_tready);
        got = predict_element(act, sel);
        pending_elems.push_back(typed ? want : got);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every element has come back.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_reg(logic idx, logic [SIDE_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {23'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_WIDTH) cfg_w = value;
        else cfg_h = value;
        walk_done = 1'b1;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {23'd0, value})
            log_fault($sformatf("register %0d read 0x%0h want 0x%0h", idx, prdata, value));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stalls, plus the long hold-off while it is requested.
    always @(negedge i_clk) begin
        if (rx_hold || rx_wait != 0) begin
            i_m_tready <= 1'b0;
            if (rx_wait != 0) rx_wait <= rx_wait - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Compares every result transfer with the oldest predicted element.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_elems.size() == 0) begin
                log_fault($sformatf("element %0d arrived with nothing expected",
                                    results_seen));
            end else begin
                want = pending_elems.pop_front();
                check_field("vertex_a", o_m_tdata[16:0], want.elem.vertex_a);
                check_field("vertex_b", o_m_tdata[33:17], want.elem.vertex_b);
                check_field("vertex_c", o_m_tdata[50:34], want.elem.vertex_c);
                check_field("length_code", o_m_tdata[52:51], want.elem.length_code);
                check_field("element_index", o_m_tdata[71:53], want.idx);
                check_field("last_element", o_m_tlast, want.last);
                check_field("element_valid", o_m_tuser[0], want.valid);
            end
            results_seen++;
            if (results_seen % 130 == 0) rx_calm <= ~rx_calm;
            rx_wait <= rx_calm ? 0 : $urandom_range(0, 14);
        end
    end

    // Long receiver hold-off so the block fills and back-pressures its input.
    initial begin
        while (requests_sent < HOLD_AFTER) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Main sequence: reset, directed script, then random phases per grid size.
    initial begin
        int unsigned widths[$];
        int unsigned heights[$];
        int unsigned n;
        logic        act;
        widths  = '{1, 0, 3, 2, 256, 511, 0, 5, 257, 1};
        heights = '{1, 3, 0, 5, 256, 300, 0, 2, 1, 9};

        // Reset values: 4 by 4 grid, stride 5, nothing started.
        script.push_back(req_known(ACT_NEXT, LIST_TRI, '0));
        script.push_back(req_known(ACT_RESTART, LIST_TRI, '0));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, elem_at(0, 1, 5, LEN_EDGE, 0, 0)));
        script.push_back(req_row(ACT_NEXT, LIST_TRI));
        script.push_back(req_known(ACT_RESTART, LIST_SPRING, '0));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, elem_at(0, 1, 0, LEN_EDGE, 0, 0)));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, elem_at(0, 6, 0, LEN_DIAG, 1, 0)));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, elem_at(0, 5, 0, LEN_EDGE, 2, 0)));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, elem_at(5, 1, 0, LEN_DIAG, 3, 0)));
        script.push_back(req_row(ACT_NEXT, LIST_NONE));
        script.push_back(req_known(ACT_RESTART, LIST_BEND, '0));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, elem_at(0, 2, 0, LEN_DOUBLE, 0, 0)));
        script.push_back(req_row(ACT_NEXT, LIST_BEND));
        // Selector three is an empty list.
        script.push_back(req_known(ACT_RESTART, LIST_NONE, '0));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, '0));
        // A register write ends the list in progress.
        script.push_back(req_known(ACT_RESTART, LIST_TRI, '0));
        script.push_back(req_row(ACT_NEXT, LIST_TRI));
        script.push_back(cfg_row(REG_WIDTH, 9'd1));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, '0));
        // Single quad: two triangles, then the list is exhausted.
        script.push_back(cfg_row(REG_HEIGHT, 9'd1));
        script.push_back(req_known(ACT_RESTART, LIST_TRI, '0));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, elem_at(0, 1, 2, LEN_EDGE, 0, 0)));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, elem_at(2, 1, 3, LEN_EDGE, 1, 1)));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, '0));
        // Bend springs of a single quad form an empty list.
        script.push_back(req_known(ACT_RESTART, LIST_BEND, '0));
        script.push_back(req_known(ACT_NEXT, LIST_TRI, '0));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[k]) begin
            if (script[k].kind == ROW_CFG) begin
                drain();
                write_reg(script[k].reg_idx, script[k].value);
            end else begin
                push_request(script[k].act, script[k].sel, script[k].typed, script[k].want);
            end
        end

        // A few extra phases with small random sizes.
        repeat (4) begin
            widths.push_back($urandom_range(0, 8));
            heights.push_back($urandom_range(0, 8));
        end

        n = 0;
        foreach (widths[p]) begin
            drain();
            write_reg(REG_WIDTH, widths[p][SIDE_W-1:0]);
            write_reg(REG_HEIGHT, heights[p][SIDE_W-1:0]);
            // Each phase starts with a restart, then mostly walks the list.
            push_request(ACT_RESTART, 2'($urandom_range(0, 2)), 1'b0, '0);
            repeat (PHASE_ITEMS) begin
                n++;
                if (n % 150 == 0) tx_calm = ~tx_calm;
                act = ($urandom_range(0, 15) == 0) ? ACT_RESTART : ACT_NEXT;
                push_request(act, 2'($urandom_range(0, 3)), 1'b0, '0);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (faults == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
